// ===== rtl/tibp_pkg.sv =====
`default_nettype none

package tibp_pkg;

    // One result record as it travels from the parser to the output queue
    typedef struct packed {
        logic [2:0]  event_kind;
        logic [7:0]  out_byte;
        logic [15:0] address;
        logic [15:0] length;
        logic [1:0]  content_type;
        logic [2:0]  error_code;
    } t_result;

    // Signature text "ZXTape!"
    function automatic logic [7:0] magic_byte(input logic [2:0] idx);
        logic [7:0] v;
        unique case (idx)
            3'd0:    v = 8'h5A;
            3'd1:    v = 8'h58;
            3'd2:    v = 8'h54;
            3'd3:    v = 8'h61;
            3'd4:    v = 8'h70;
            3'd5:    v = 8'h65;
            3'd6:    v = 8'h21;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/tibp_front.sv =====
`default_nettype none

module tibp_front
    import tibp_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire logic       i_req_type,
    input  wire logic [7:0] i_file_byte,
    output logic            o_push,
    output t_result         o_result
);

    // Parser phases
    localparam logic [3:0] PH_SIG     = 4'd0;
    localparam logic [3:0] PH_ID      = 4'd1;
    localparam logic [3:0] PH_PAUSE   = 4'd2;
    localparam logic [3:0] PH_LEN     = 4'd3;
    localparam logic [3:0] PH_FLAG    = 4'd4;
    localparam logic [3:0] PH_BODY    = 4'd5;
    localparam logic [3:0] PH_TEXTLEN = 4'd6;
    localparam logic [3:0] PH_TEXT    = 4'd7;
    localparam logic [3:0] PH_DONE    = 4'd8;

    // Result kinds
    localparam logic [2:0] EV_PROG   = 3'd0;
    localparam logic [2:0] EV_MEM    = 3'd1;
    localparam logic [2:0] EV_HDR    = 3'd2;
    localparam logic [2:0] EV_DATA   = 3'd3;
    localparam logic [2:0] EV_FINISH = 3'd4;
    localparam logic [2:0] EV_ERROR  = 3'd5;

    // Error codes
    localparam logic [2:0] ERR_SIG    = 3'd0;
    localparam logic [2:0] ERR_ID     = 3'd1;
    localparam logic [2:0] ERR_CSUM   = 3'd2;
    localparam logic [2:0] ERR_HLEN   = 3'd3;
    localparam logic [2:0] ERR_HTYPE  = 3'd4;
    localparam logic [2:0] ERR_FLAG   = 3'd5;
    localparam logic [2:0] ERR_TRUNC  = 3'd6;

    localparam logic [7:0]  ID_STD      = 8'h10;
    localparam logic [7:0]  ID_TEXT     = 8'h30;
    localparam logic [7:0]  FLAG_HDR    = 8'h00;
    localparam logic [7:0]  FLAG_DATA   = 8'hFF;
    localparam logic [15:0] HDR_BLK_LEN = 16'd19;  // 17 payload bytes + flag + checksum
    localparam logic [7:0]  TYPE_PROG   = 8'd0;
    localparam logic [7:0]  TYPE_CODE   = 8'd3;

    logic [3:0]  r_phase,     n_phase;
    logic [15:0] r_count,     n_count;
    logic [15:0] r_blk_len,   n_blk_len;
    logic [7:0]  r_xor,       n_xor;
    logic [7:0]  r_flag,      n_flag;
    logic [7:0]  r_p_type,    n_p_type;
    logic [15:0] r_p_len,     n_p_len;
    logic [15:0] r_p_param,   n_p_param;
    logic [1:0]  r_s_type,    n_s_type;
    logic        r_have_hdr,  n_have_hdr;
    logic [15:0] r_s_addr,    n_s_addr;
    logic [15:0] r_s_len,     n_s_len;
    logic [15:0] r_start,     n_start;

    logic [15:0] len_new;
    logic [7:0]  xor_new;
    logic [16:0] idx_plus2;
    logic        blk_last;
    logic [15:0] count_dec;
    logic [15:0] count_inc;
    logic [15:0] mem_addr;

    assign len_new   = {i_file_byte, r_blk_len[7:0]};
    assign xor_new   = r_xor ^ i_file_byte;
    assign idx_plus2 = {1'b0, r_count} + 17'd2;
    assign blk_last  = idx_plus2 >= {1'b0, r_blk_len};
    assign count_dec = r_count - 16'd1;
    assign count_inc = r_count + 16'd1;
    assign mem_addr  = r_s_addr + r_count;

    // Per-byte parse step
    always_comb begin
        n_phase    = r_phase;
        n_count    = r_count;
        n_blk_len  = r_blk_len;
        n_xor      = r_xor;
        n_flag     = r_flag;
        n_p_type   = r_p_type;
        n_p_len    = r_p_len;
        n_p_param  = r_p_param;
        n_s_type   = r_s_type;
        n_have_hdr = r_have_hdr;
        n_s_addr   = r_s_addr;
        n_s_len    = r_s_len;
        n_start    = r_start;
        o_push     = 1'b0;
        o_result   = '0;

        if (i_accept && (r_phase != PH_DONE)) begin
            if (i_req_type) begin
                // end of input: clean only at a block boundary
                o_push  = 1'b1;
                n_phase = PH_DONE;
                if (r_phase == PH_ID) begin
                    o_result.event_kind = EV_FINISH;
                    o_result.address    = r_start;
                end else begin
                    o_result.event_kind = EV_ERROR;
                    o_result.error_code = ERR_TRUNC;
                end
            end else begin
                unique case (r_phase)
                    PH_SIG: begin
                        if ((r_count < 16'd7) && (i_file_byte != magic_byte(r_count[2:0]))) begin
                            o_push              = 1'b1;
                            n_phase             = PH_DONE;
                            o_result.event_kind = EV_ERROR;
                            o_result.error_code = ERR_SIG;
                        end else if (count_inc >= 16'd10) begin
                            n_count = '0;
                            n_phase = PH_ID;
                        end else begin
                            n_count = count_inc;
                        end
                    end
                    PH_ID: begin
                        n_count = '0;
                        if (i_file_byte == ID_STD) begin
                            n_phase = PH_PAUSE;
                        end else if (i_file_byte == ID_TEXT) begin
                            n_phase = PH_TEXTLEN;
                        end else begin
                            o_push              = 1'b1;
                            n_phase             = PH_DONE;
                            o_result.event_kind = EV_ERROR;
                            o_result.error_code = ERR_ID;
                        end
                    end
                    PH_PAUSE: begin
                        if (r_count != 16'd0) begin
                            n_count = '0;
                            n_phase = PH_LEN;
                        end else begin
                            n_count = count_inc;
                        end
                    end
                    PH_LEN: begin
                        if (r_count == 16'd0) begin
                            n_blk_len = {8'd0, i_file_byte};
                            n_count   = 16'd1;
                        end else begin
                            n_blk_len = len_new;
                            n_count   = '0;
                            if (len_new < 16'd2) begin
                                o_push              = 1'b1;
                                n_phase             = PH_DONE;
                                o_result.event_kind = EV_ERROR;
                                o_result.error_code = ERR_TRUNC;
                            end else begin
                                n_phase = PH_FLAG;
                            end
                        end
                    end
                    PH_FLAG: begin
                        n_flag    = i_file_byte;
                        n_xor     = i_file_byte;
                        n_p_type  = '0;
                        n_p_len   = '0;
                        n_p_param = '0;
                        n_count   = '0;
                        n_phase   = PH_BODY;
                    end
                    PH_BODY: begin
                        n_xor = xor_new;
                        if (blk_last) begin
                            // checksum byte: judge the block
                            o_push  = 1'b1;
                            n_phase = PH_ID;
                            if (xor_new != 8'd0) begin
                                n_phase             = PH_DONE;
                                o_result.event_kind = EV_ERROR;
                                o_result.error_code = ERR_CSUM;
                            end else if (r_flag == FLAG_HDR) begin
                                if (r_blk_len != HDR_BLK_LEN) begin
                                    n_phase             = PH_DONE;
                                    o_result.event_kind = EV_ERROR;
                                    o_result.error_code = ERR_HLEN;
                                end else if ((r_p_type != TYPE_PROG)
                                             && (r_p_type != TYPE_CODE)) begin
                                    n_phase             = PH_DONE;
                                    o_result.event_kind = EV_ERROR;
                                    o_result.error_code = ERR_HTYPE;
                                end else begin
                                    if (r_p_type == TYPE_PROG) begin
                                        n_start = r_p_param;
                                    end
                                    n_s_type              = r_p_type[1:0];
                                    n_s_addr              = r_p_param;
                                    n_s_len               = r_p_len;
                                    n_have_hdr            = 1'b1;
                                    o_result.event_kind   = EV_HDR;
                                    o_result.address      = r_p_param;
                                    o_result.length       = r_p_len;
                                    o_result.content_type = r_p_type[1:0];
                                end
                            end else if (r_flag != FLAG_DATA) begin
                                n_phase             = PH_DONE;
                                o_result.event_kind = EV_ERROR;
                                o_result.error_code = ERR_FLAG;
                            end else begin
                                o_result.event_kind = EV_DATA;
                            end
                        end else begin
                            n_count = count_inc;
                            if (r_flag == FLAG_HDR) begin
                                // capture type, length and param1
                                if (r_count == 16'd0)  n_p_type         = i_file_byte;
                                if (r_count == 16'd11) n_p_len[7:0]     = i_file_byte;
                                if (r_count == 16'd12) n_p_len[15:8]    = i_file_byte;
                                if (r_count == 16'd13) n_p_param[7:0]   = i_file_byte;
                                if (r_count == 16'd14) n_p_param[15:8]  = i_file_byte;
                            end else if ((r_flag == FLAG_DATA) && r_have_hdr) begin
                                if (r_s_type == TYPE_PROG[1:0]) begin
                                    o_push              = 1'b1;
                                    o_result.event_kind = EV_PROG;
                                    o_result.out_byte   = i_file_byte;
                                end else if ((r_s_type == TYPE_CODE[1:0])
                                             && (r_count < r_s_len)) begin
                                    o_push              = 1'b1;
                                    o_result.event_kind = EV_MEM;
                                    o_result.out_byte   = i_file_byte;
                                    o_result.address    = mem_addr;
                                end
                            end
                        end
                    end
                    PH_TEXTLEN: begin
                        n_count = {8'd0, i_file_byte};
                        n_phase = (i_file_byte == 8'd0) ? PH_ID : PH_TEXT;
                    end
                    PH_TEXT: begin
                        n_count = count_dec;
                        if (count_dec == 16'd0) begin
                            n_phase = PH_ID;
                        end
                    end
                    default: begin
                        n_phase = r_phase;
                    end
                endcase
            end
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_SIG;
            r_count    <= '0;
            r_blk_len  <= '0;
            r_xor      <= '0;
            r_flag     <= '0;
            r_p_type   <= '0;
            r_p_len    <= '0;
            r_p_param  <= '0;
            r_s_type   <= '0;
            r_have_hdr <= 1'b0;
            r_s_addr   <= '0;
            r_s_len    <= '0;
            r_start    <= '0;
        end else begin
            r_phase    <= n_phase;
            r_count    <= n_count;
            r_blk_len  <= n_blk_len;
            r_xor      <= n_xor;
            r_flag     <= n_flag;
            r_p_type   <= n_p_type;
            r_p_len    <= n_p_len;
            r_p_param  <= n_p_param;
            r_s_type   <= n_s_type;
            r_have_hdr <= n_have_hdr;
            r_s_addr   <= n_s_addr;
            r_s_len    <= n_s_len;
            r_start    <= n_start;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/tibp_queue.sv =====
`default_nettype none

module tibp_queue
    import tibp_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  t_result      i_data,
    output logic         o_full,
    output logic         o_valid,
    input  wire logic    i_ready,
    output t_result      o_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    t_result         r_mem [DEPTH];
    logic [AW-1:0]   r_wr, r_rd;
    logic [CW-1:0]   r_cnt;
    logic            pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign pop     = o_valid && i_ready;

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == LAST) ? '0 : r_wr + AW'(1);
            end
            if (pop) begin
                r_rd <= (r_rd == LAST) ? '0 : r_rd + AW'(1);
            end
            if (i_push && !pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (pop && !i_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/tape_image_block_parser.sv =====
// Results: each result is registered in the result queue before it reaches the outputs.
// Throughput: one byte per cycle; the parser steps once per accepted byte, and input
// stalls only when the result queue (QUEUE_DEPTH entries) is full.
// Reset: synchronous, active low; parser returns to the signature phase, queue empties.
`default_nettype none

module tape_image_block_parser
    import tibp_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_req_type,
    input  wire logic [7:0]  i_file_byte,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [2:0]       o_event_kind,
    output logic [7:0]       o_out_byte,
    output logic [15:0]      o_address,
    output logic [15:0]      o_length,
    output logic [1:0]       o_content_type,
    output logic [2:0]       o_error_code
);

    logic    accept;
    logic    push;
    logic    full;
    t_result front_res;
    t_result back_res;

    assign o_ready = !full;
    assign accept  = i_valid && o_ready;

    // Front: parse and classify each byte
    tibp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_req_type  (i_req_type),
        .i_file_byte (i_file_byte),
        .o_push      (push),
        .o_result    (front_res)
    );

    // Back: result queue toward the consumer
    tibp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_res),
        .o_full  (full),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (back_res)
    );

    assign o_event_kind   = back_res.event_kind;
    assign o_out_byte     = back_res.out_byte;
    assign o_address      = back_res.address;
    assign o_length       = back_res.length;
    assign o_content_type = back_res.content_type;
    assign o_error_code   = back_res.error_code;

endmodule

`default_nettype wire
